// ===== design/rfcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the RTCM3 frame CRC checker.
// No dependencies; imported by every module of the block.
package rfcc_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W = 10;
  localparam int CRC_W = 24;
  localparam int STATUS_W = 3;
  localparam int PHASE_W = 3;
  localparam int TIDX_W = 2;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hD3;
  localparam logic [BYTE_W-1:0] RESERVED_MASK = 8'hFC;
  // CRC-24Q polynomial 0x1864CFB without its implicit top bit
  localparam logic [CRC_W-1:0] CRC_POLY = 24'h864CFB;

  // Frame parser phases
  localparam logic [PHASE_W-1:0] PH_SYNC = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LEN_HI = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEN_LO = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
  localparam logic [PHASE_W-1:0] PH_TRAILER = 3'd4;

  // Frame status codes
  localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SYNC = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CRC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd4;

  // Trailer byte positions, most significant CRC byte first
  localparam logic [TIDX_W-1:0] TIDX_HI = 2'd0;
  localparam logic [TIDX_W-1:0] TIDX_MID = 2'd1;
  localparam logic [TIDX_W-1:0] TIDX_LO = 2'd2;

  typedef struct packed {
    logic                has_result;
    logic                frame_done;
    logic [STATUS_W-1:0] frame_status;
    logic [LEN_W-1:0]    payload_length;
    logic                buffer_done;
    logic                buffer_ok;
  } rfcc_result_t;

endpackage

// ===== design/rfcc_crc24q.sv =====
`timescale 1ns / 1ps
// Byte-wide CRC-24Q update, purely combinational.
// Depends on rfcc_pkg for widths and the polynomial.
module rfcc_crc24q (
  input  logic [rfcc_pkg::CRC_W-1:0]  crc_in,
  input  logic [rfcc_pkg::BYTE_W-1:0] data,
  output logic [rfcc_pkg::CRC_W-1:0]  crc_out
);
  import rfcc_pkg::*;

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ {data, {(CRC_W - BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ===== design/rfcc_frame_fsm.sv =====
`timescale 1ns / 1ps
// Frame parser: sync, header, payload and trailer tracking with the running CRC.
// Depends on rfcc_pkg and rfcc_crc24q.
module rfcc_frame_fsm (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [rfcc_pkg::BYTE_W-1:0] data_byte,
  input  logic                        buffer_end,
  output rfcc_pkg::rfcc_result_t      result
);
  import rfcc_pkg::*;

  logic [PHASE_W-1:0] phase, phase_next;
  logic [LEN_W-1:0]   length_value, length_value_next;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;
  logic [CRC_W-1:0]   crc_register, crc_register_next;
  logic [TIDX_W-1:0]  trailer_index, trailer_index_next;
  logic               crc_mismatch_seen, crc_mismatch_seen_next;
  logic               discarding, discarding_next;
  logic               buffer_failed, buffer_failed_next;

  logic [CRC_W-1:0]   crc_in;
  logic [CRC_W-1:0]   crc_upd;

  // A sync byte restarts the CRC from zero
  assign crc_in = (phase == PH_LEN_HI || phase == PH_LEN_LO || phase == PH_PAYLOAD ||
                   phase == PH_TRAILER) ? crc_register : '0;

  rfcc_crc24q u_crc (
    .crc_in (crc_in),
    .data   (data_byte),
    .crc_out(crc_upd)
  );

  always_comb begin
    logic               fdone;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]   plen;
    logic [LEN_W-1:0]   len_tmp;
    logic [BYTE_W-1:0]  expect_byte;
    logic               mism;

    phase_next = phase;
    length_value_next = length_value;
    bytes_left_next = bytes_left;
    crc_register_next = crc_register;
    trailer_index_next = trailer_index;
    crc_mismatch_seen_next = crc_mismatch_seen;
    discarding_next = discarding;
    buffer_failed_next = buffer_failed;
    fdone = 1'b0;
    status = ST_OK;
    plen = '0;
    len_tmp = '0;
    expect_byte = '0;
    mism = 1'b0;

    if (!discarding) begin
      unique case (phase)
        PH_LEN_HI: begin
          if ((data_byte & RESERVED_MASK) != '0) begin
            fdone = 1'b1;
            status = ST_RESERVED;
          end else begin
            length_value_next = {data_byte[1:0], {(LEN_W - 2){1'b0}}};
            crc_register_next = crc_upd;
            phase_next = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          len_tmp = length_value | {{(LEN_W - BYTE_W){1'b0}}, data_byte};
          length_value_next = len_tmp;
          crc_register_next = crc_upd;
          bytes_left_next = len_tmp;
          trailer_index_next = TIDX_HI;
          crc_mismatch_seen_next = 1'b0;
          phase_next = (len_tmp != '0) ? PH_PAYLOAD : PH_TRAILER;
        end
        PH_PAYLOAD: begin
          crc_register_next = crc_upd;
          bytes_left_next = bytes_left - LEN_W'(1);
          if (bytes_left_next == '0) begin
            phase_next = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          unique case (trailer_index)
            TIDX_HI:  expect_byte = crc_register[23:16];
            TIDX_MID: expect_byte = crc_register[15:8];
            TIDX_LO:  expect_byte = crc_register[7:0];
            default:  expect_byte = '0;
          endcase
          mism = crc_mismatch_seen | (expect_byte != data_byte);
          crc_mismatch_seen_next = mism;
          if (trailer_index >= TIDX_LO) begin
            fdone = 1'b1;
            status = mism ? ST_CRC : ST_OK;
            plen = length_value;
            phase_next = PH_SYNC;
            trailer_index_next = TIDX_HI;
          end else begin
            trailer_index_next = trailer_index + TIDX_W'(1);
          end
        end
        default: begin
          if (data_byte != SYNC_BYTE) begin
            fdone = 1'b1;
            status = ST_BAD_SYNC;
          end else begin
            length_value_next = '0;
            bytes_left_next = '0;
            trailer_index_next = TIDX_HI;
            crc_mismatch_seen_next = 1'b0;
            crc_register_next = crc_upd;
            phase_next = PH_LEN_HI;
          end
        end
      endcase

      if (fdone && status != ST_OK) begin
        discarding_next = 1'b1;
        buffer_failed_next = 1'b1;
      end
      if (buffer_end && !fdone && phase_next != PH_SYNC) begin
        fdone = 1'b1;
        status = ST_TRUNCATED;
        plen = (phase_next == PH_PAYLOAD || phase_next == PH_TRAILER) ?
               length_value_next : '0;
        buffer_failed_next = 1'b1;
      end
    end

    result.has_result = fdone | buffer_end;
    result.frame_done = fdone;
    result.frame_status = status;
    result.payload_length = plen;
    result.buffer_done = buffer_end;
    result.buffer_ok = buffer_end & ~buffer_failed_next;

    // The buffer's last byte returns everything to the idle state
    if (buffer_end) begin
      phase_next = PH_SYNC;
      length_value_next = '0;
      bytes_left_next = '0;
      crc_register_next = '0;
      trailer_index_next = TIDX_HI;
      crc_mismatch_seen_next = 1'b0;
      discarding_next = 1'b0;
      buffer_failed_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC;
      length_value <= '0;
      bytes_left <= '0;
      crc_register <= '0;
      trailer_index <= TIDX_HI;
      crc_mismatch_seen <= 1'b0;
      discarding <= 1'b0;
      buffer_failed <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      length_value <= length_value_next;
      bytes_left <= bytes_left_next;
      crc_register <= crc_register_next;
      trailer_index <= trailer_index_next;
      crc_mismatch_seen <= crc_mismatch_seen_next;
      discarding <= discarding_next;
      buffer_failed <= buffer_failed_next;
    end
  end

endmodule

// ===== design/rtcm3_frame_crc_checker_top.sv =====
`timescale 1ns / 1ps
// Top level of the RTCM3 frame CRC checker: input register, frame parser, result register.
// Depends on rfcc_pkg and rfcc_frame_fsm.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------------
//   input   | in_valid / in_ready | data_byte, buffer_end
//   output  | out_valid/out_ready | frame_done, frame_status, payload_length,
//           |                     | buffer_done, buffer_ok
//
// One byte per cycle sustained unless the result stalls; a byte passes from the input
// register to the result register, with the CRC update and frame logic between the two.
// Bytes that end neither a frame nor the buffer give no result transfer.
// Synchronous reset returns the parser to waiting for a sync byte and empties both registers.
// A stalled result holds the input register; a new byte still enters while the result waits
// as long as the input register is free.
module rtcm3_frame_crc_checker_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rfcc_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          buffer_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          frame_done,
  output logic [rfcc_pkg::STATUS_W-1:0] frame_status,
  output logic [rfcc_pkg::LEN_W-1:0]    payload_length,
  output logic                          buffer_done,
  output logic                          buffer_ok
);
  import rfcc_pkg::*;

  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              step;
  rfcc_result_t      result;

  // Process the held byte when the result register is free or being drained
  assign step = in_full & (~out_valid | out_ready);
  assign in_ready = ~in_full | step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
      in_last <= buffer_end;
    end
  end

  rfcc_frame_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .buffer_end(in_last),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= result.has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result.has_result) begin
      frame_done <= result.frame_done;
      frame_status <= result.frame_status;
      payload_length <= result.payload_length;
      buffer_done <= result.buffer_done;
      buffer_ok <= result.buffer_ok;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_has_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_done || buffer_done))
    else $error("result without frame or buffer event");

  a_idle_frame_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_done) |-> (frame_status == ST_OK && payload_length == '0))
    else $error("frame fields set without frame_done");

  a_ok_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !buffer_done) |-> !buffer_ok)
    else $error("buffer_ok outside buffer end");

  a_header_fail_no_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done && (frame_status == ST_BAD_SYNC ||
     frame_status == ST_RESERVED)) |-> (payload_length == '0 && !buffer_ok))
    else $error("header failure carries length or passing verdict");

  a_step_only_with_data: assert property (@(posedge clk) disable iff (rst)
    (step && result.has_result) |=> out_valid)
    else $error("result lost at output register");
`endif

endmodule

// ===== test/rtcm3_frame_crc_checker_top_test.sv =====
`timescale 1ns / 1ps
// Testbench for rtcm3_frame_crc_checker_top: streams RTCM3 buffers and checks frame reports.
// Depends on rfcc_pkg and the design sources; no files or arguments are read.
module rtcm3_frame_crc_checker_top_test;
  import rfcc_pkg::*;

  localparam int GAP_PCT = 78;
  localparam int BOTH_PCT = 8;
  localparam int PHASE_BYTES = 200;
  localparam int MAX_SHOWN = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {FAULT_NONE, FAULT_SYNC, FAULT_RESERVED, FAULT_CRC} frame_fault_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } rx_byte_t;

  typedef struct packed {
    logic                frame_done;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    plen;
    logic                buf_done;
    logic                buf_ok;
  } frame_report_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   left;
    logic [CRC_W-1:0]   crc;
    logic [TIDX_W-1:0]  tidx;
    logic               mis;
    logic               discard;
    logic               failed;
  } parser_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [BYTE_W-1:0] data_byte = '0;
  logic buffer_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic frame_done;
  logic [STATUS_W-1:0] frame_status;
  logic [LEN_W-1:0] payload_length;
  logic buffer_done;
  logic buffer_ok;

  rx_byte_t          tx_byte_q[$];
  logic [BYTE_W-1:0] stage_q[$];
  frame_report_t     report_q[$];
  parser_state_t     chk = '0;
  idle_mode_t        idle_mode = IDLE_NONE;
  logic              byte_taken = 1'b0;
  int                err_count = 0;
  int                staged_bytes = 0;

  rtcm3_frame_crc_checker_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .buffer_end    (buffer_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_done    (frame_done),
    .frame_status  (frame_status),
    .payload_length(payload_length),
    .buffer_done   (buffer_done),
    .buffer_ok     (buffer_ok)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bitwise CRC-24Q, one byte, MSB first
  function automatic logic [CRC_W-1:0] crc24q_next(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic predict_frame_report(input logic [BYTE_W-1:0] b, input logic last);
    logic              fdone;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]  plen;
    logic [BYTE_W-1:0] want;
    frame_report_t     rep;
    fdone = 1'b0;
    status = ST_OK;
    plen = '0;
    if (!chk.discard) begin
      case (chk.phase)
        PH_LEN_HI: begin
          if ((b & RESERVED_MASK) != '0) begin
            fdone = 1'b1;
            status = ST_RESERVED;
          end else begin
            chk.len = {b[1:0], 8'h00};
            chk.crc = crc24q_next(chk.crc, b);
            chk.phase = PH_LEN_LO;
          end
        end
        PH_LEN_LO: begin
          chk.len = {chk.len[9:8], b};
          chk.crc = crc24q_next(chk.crc, b);
          chk.left = chk.len;
          chk.tidx = TIDX_HI;
          chk.mis = 1'b0;
          chk.phase = (chk.len != '0) ? PH_PAYLOAD : PH_TRAILER;
        end
        PH_PAYLOAD: begin
          chk.crc = crc24q_next(chk.crc, b);
          chk.left = chk.left - LEN_W'(1);
          if (chk.left == '0) chk.phase = PH_TRAILER;
        end
        PH_TRAILER: begin
          case (chk.tidx)
            TIDX_HI:  want = chk.crc[23:16];
            TIDX_MID: want = chk.crc[15:8];
            default:  want = chk.crc[7:0];
          endcase
          if (want != b) chk.mis = 1'b1;
          if (chk.tidx >= TIDX_LO) begin
            fdone = 1'b1;
            status = chk.mis ? ST_CRC : ST_OK;
            plen = chk.len;
            chk.phase = PH_SYNC;
            chk.tidx = TIDX_HI;
          end else begin
            chk.tidx = chk.tidx + TIDX_W'(1);
          end
        end
        default: begin
          if (b != SYNC_BYTE) begin
            fdone = 1'b1;
            status = ST_BAD_SYNC;
          end else begin
            chk.len = '0;
            chk.left = '0;
            chk.tidx = TIDX_HI;
            chk.mis = 1'b0;
            chk.crc = crc24q_next('0, b);
            chk.phase = PH_LEN_HI;
          end
        end
      endcase
      if (fdone && status != ST_OK) begin
        chk.discard = 1'b1;
        chk.failed = 1'b1;
      end
      if (last && !fdone && chk.phase != PH_SYNC) begin
        fdone = 1'b1;
        status = ST_TRUNCATED;
        plen = (chk.phase == PH_PAYLOAD || chk.phase == PH_TRAILER) ? chk.len : '0;
        chk.failed = 1'b1;
      end
    end
    if (fdone || last) begin
      rep = '{fdone, status, plen, last, last && !chk.failed};
      report_q.push_back(rep);
    end
    if (last) chk = '0;
  endtask

  task automatic flag_error(input string msg);
    if (err_count < MAX_SHOWN) $display("%s", msg);
    err_count++;
  endtask

  // Build one frame into the staging queue; a fault corrupts exactly one aspect
  task automatic stage_frame(input logic [LEN_W-1:0] plen, input frame_fault_t fault);
    logic [BYTE_W-1:0] hdr[3];
    logic [BYTE_W-1:0] b;
    logic [CRC_W-1:0]  crc;
    int                bad_pos;
    hdr[0] = SYNC_BYTE;
    hdr[1] = {6'b000000, plen[9:8]};
    hdr[2] = plen[7:0];
    crc = '0;
    for (int k = 0; k < 3; k++) crc = crc24q_next(crc, hdr[k]);
    if (fault == FAULT_SYNC) begin
      do b = BYTE_W'($urandom_range(255)); while (b == SYNC_BYTE);
      hdr[0] = b;
    end
    if (fault == FAULT_RESERVED) hdr[1][7:2] = 6'($urandom_range(1, 63));
    for (int k = 0; k < 3; k++) stage_q.push_back(hdr[k]);
    for (int k = 0; k < plen; k++) begin
      b = BYTE_W'($urandom_range(255));
      crc = crc24q_next(crc, b);
      stage_q.push_back(b);
    end
    if (fault == FAULT_CRC) begin
      bad_pos = $urandom_range(2);
      crc = crc ^ (CRC_W'($urandom_range(1, 255)) << (8 * bad_pos));
    end
    stage_q.push_back(crc[23:16]);
    stage_q.push_back(crc[15:8]);
    stage_q.push_back(crc[7:0]);
  endtask

  // Move the staged bytes to the driver, dropping cut bytes from the tail
  task automatic ship_buffer(input int cut);
    rx_byte_t item;
    int       n;
    n = stage_q.size() - cut;
    if (n < 1) n = 1;
    for (int k = 0; k < n; k++) begin
      item.data = stage_q[k];
      item.last = (k == n - 1);
      tx_byte_q.push_back(item);
    end
    staged_bytes += n;
    stage_q.delete();
  endtask

  task automatic random_buffer();
    int                frames;
    int                start;
    int                roll;
    logic [LEN_W-1:0]  plen;
    logic [BYTE_W-1:0] b;
    frame_fault_t      fault;
    start = 0;
    if ($urandom_range(99) < 10) begin
      frames = $urandom_range(1, 6);
      for (int k = 0; k < frames; k++) begin
        b = BYTE_W'($urandom_range(255));
        stage_q.push_back(b);
      end
      if ($urandom_range(1)) stage_q[0] = SYNC_BYTE;
      ship_buffer(0);
    end else begin
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        start = stage_q.size();
        roll = $urandom_range(99);
        if (roll < 70) plen = LEN_W'($urandom_range(8));
        else if (roll < 95) plen = LEN_W'($urandom_range(9, 40));
        else plen = LEN_W'($urandom_range(41, 200));
        if ($urandom_range(99) < 78) fault = FAULT_NONE;
        else fault = frame_fault_t'($urandom_range(1, 3));
        stage_frame(plen, fault);
      end
      // end the buffer inside the last frame now and then
      if ($urandom_range(99) < 15) ship_buffer($urandom_range(1, stage_q.size() - start - 1));
      else ship_buffer(0);
    end
  endtask

  // Driver: advance or hold the byte at the falling edge
  always @(negedge clk) begin
    rx_byte_t nxt;
    int       roll;
    if (!rst) begin
      if (!in_valid || byte_taken) begin
        roll = $urandom_range(99);
        if (tx_byte_q.size() > 0 &&
            !((idle_mode == IDLE_SENDER && roll < GAP_PCT) ||
              (idle_mode == IDLE_BOTH && roll < BOTH_PCT))) begin
          nxt = tx_byte_q.pop_front();
          in_valid <= 1'b1;
          data_byte <= nxt.data;
          buffer_end <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      roll = $urandom_range(99);
      out_ready <= !((idle_mode == IDLE_RECEIVER && roll < GAP_PCT) ||
                     (idle_mode == IDLE_BOTH && roll < BOTH_PCT));
    end
  end

  // Monitor: predict on every input transfer, check every result transfer
  always @(posedge clk) begin
    frame_report_t got;
    frame_report_t want;
    byte_taken <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) predict_frame_report(data_byte, buffer_end);
    if (!rst && out_valid && out_ready) begin
      got = '{frame_done, frame_status, payload_length, buffer_done, buffer_ok};
      if (report_q.size() == 0) begin
        flag_error($sformatf("unexpected result: done=%0d status=%0d len=%0d bend=%0d bok=%0d",
                             got.frame_done, got.status, got.plen, got.buf_done, got.buf_ok));
      end else begin
        want = report_q.pop_front();
        if (got !== want)
          flag_error($sformatf({"mismatch: expected done=%0d status=%0d len=%0d bend=%0d bok=%0d,",
                                " got done=%0d status=%0d len=%0d bend=%0d bok=%0d"},
                               want.frame_done, want.status, want.plen, want.buf_done,
                               want.buf_ok, got.frame_done, got.status, got.plen,
                               got.buf_done, got.buf_ok));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int target;
    // short directed buffers
    stage_frame(LEN_W'(0), FAULT_NONE);
    ship_buffer(0);
    stage_q.push_back(8'h00);
    ship_buffer(0);
    stage_q.push_back(SYNC_BYTE);
    stage_q.push_back(8'hFC);
    ship_buffer(0);
    stage_q.push_back(SYNC_BYTE);
    stage_q.push_back(8'h00);
    ship_buffer(0);
    stage_frame(10'd1023, FAULT_NONE);
    ship_buffer(stage_q.size() - 4);
    stage_frame(LEN_W'(0), FAULT_CRC);
    stage_q.push_back(8'h55);
    ship_buffer(0);
    stage_frame(LEN_W'(1), FAULT_NONE);
    ship_buffer(1);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
      idle_mode = idle_mode_t'(m);
      target = staged_bytes + PHASE_BYTES;
      while (staged_bytes < target) random_buffer();
      while (tx_byte_q.size() != 0 || in_valid) @(posedge clk);
    end

    while (report_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0 && report_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
